### src/rrqq_pkg.sv
package rrqq_pkg;

  localparam int unsigned QueueDepthDefault = 64;

  localparam int unsigned JOB_W       = 16;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned MEAN_W      = 24;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = CMD_W;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_TUSER_W = STATUS_W;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - (JOB_W + 1 + MEAN_W);

  localparam logic [JOB_W-1:0] QUANTUM_RESET = JOB_W'(1);

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SERVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_AVG   = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_SERVED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_ADDED   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_ZERO    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_AVERAGE = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_AVG  = 4'b1000
  } state_e;

endpackage

### src/rrqq_ram.sv
module rrqq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/rrqq_div.sv
module rrqq_div #(
  parameter int unsigned DVD_W = 31,
  parameter int unsigned DVS_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]  quot_q, quot_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;

  assign trial = {rem_q, quot_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = LAST_STEP;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[DVD_W-2:0], fits};
      rem_d  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_d  = cnt_q - STEP_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

### src/round_robin_quantum_queue_top.sv
// Round-robin time-slice scheduler over a FIFO of up to QUEUE_DEPTH job times held in one
// single-port-write, registered-read RAM. Each command beat is taken on s_axis and gives one
// result beat on m_axis (command 3 gives none). For add and serve the accept cycle reads the
// oldest job from RAM; S_EXEC updates the queue once the result slot is free, writing the new
// job or a serve remainder at the tail. Average uses a restoring divider retiring one quotient
// bit per cycle over DVD_W dividend bits (31 at the default depth). A new beat is taken once
// the previous command is finished, even while its result beat waits on m_axis_tready_i.
// The user writes the quantum register via cfg_we_i/cfg_wdata_i only while idle (unchecked).
module round_robin_quantum_queue_top #(
  parameter int unsigned QUEUE_DEPTH = rrqq_pkg::QueueDepthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rrqq_pkg::JOB_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [rrqq_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,  // [15:0] job_time
  input  logic [rrqq_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,  // [1:0] command
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [rrqq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,  // [15:0] granted, [16] job_done,
                                                            // [40:17] mean_time, rest zero
  output logic [rrqq_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o   // [2:0] status
);

  localparam int unsigned JOB_W = rrqq_pkg::JOB_W;
  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = JOB_W + CNT_W;
  localparam int unsigned DVD_W = SUM_W + rrqq_pkg::FRAC_W;
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  rrqq_pkg::state_e state_q, state_d;

  logic [rrqq_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [JOB_W-1:0]           jt_q, jt_d;
  logic [JOB_W-1:0]           quantum_q, quantum_d;
  logic [PTR_W-1:0]           head_q, head_d;
  logic [PTR_W-1:0]           tail_q, tail_d;
  logic [CNT_W-1:0]           count_q, count_d;
  logic [SUM_W-1:0]           sum_q, sum_d;

  logic                          out_valid_q, out_valid_d;
  logic [rrqq_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [JOB_W-1:0]              out_granted_q, out_granted_d;
  logic                          out_done_q, out_done_d;
  logic [rrqq_pkg::MEAN_W-1:0]   out_mean_q, out_mean_d;

  logic             in_beat;
  logic             out_free;
  logic             empty;
  logic [PTR_W-1:0] head_nxt;
  logic [PTR_W-1:0] tail_nxt;
  logic             ram_we;
  logic [JOB_W-1:0] ram_wdata;
  logic [JOB_W-1:0] ram_rdata;
  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;
  logic [SUM_W-1:0] jt_ext;
  logic [SUM_W-1:0] quantum_ext;
  logic [SUM_W-1:0] rdata_ext;

  assign s_axis_tready_o = (state_q == rrqq_pkg::S_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign empty           = (count_q == '0);
  assign head_nxt        = (head_q == LAST_PTR) ? '0 : head_q + PTR_W'(1);
  assign tail_nxt        = (tail_q == LAST_PTR) ? '0 : tail_q + PTR_W'(1);
  assign jt_ext          = {{(SUM_W - JOB_W){1'b0}}, jt_q};
  assign quantum_ext     = {{(SUM_W - JOB_W){1'b0}}, quantum_q};
  assign rdata_ext       = {{(SUM_W - JOB_W){1'b0}}, ram_rdata};

  rrqq_ram #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(ram_wdata),
    .re_i   (in_beat),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  rrqq_div #(
    .DVD_W(DVD_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({sum_q, {rrqq_pkg::FRAC_W{1'b0}}}),
    .divisor_i (count_q),
    .done_o    (div_done),
    .quotient_o(div_quot)
  );

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    jt_d          = jt_q;
    quantum_d     = cfg_we_i ? cfg_wdata_i : quantum_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    sum_d         = sum_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_status_d  = out_status_q;
    out_granted_d = out_granted_q;
    out_done_d    = out_done_q;
    out_mean_d    = out_mean_q;
    ram_we        = 1'b0;
    ram_wdata     = jt_q;
    div_start     = 1'b0;

    unique case (state_q)
      rrqq_pkg::S_IDLE: begin
        if (in_beat) begin
          cmd_d   = s_axis_tuser_i;
          jt_d    = s_axis_tdata_i;
          state_d = rrqq_pkg::S_EXEC;
        end
      end
      rrqq_pkg::S_EXEC: begin
        unique case (cmd_q)
          rrqq_pkg::CMD_ADD: begin
            if (out_free) begin
              out_valid_d   = 1'b1;
              out_granted_d = '0;
              out_done_d    = 1'b0;
              out_mean_d    = '0;
              state_d       = rrqq_pkg::S_IDLE;
              if (jt_q == '0) begin
                out_status_d = rrqq_pkg::STAT_ZERO;
              end else if (count_q >= DEPTH_CNT) begin
                out_status_d = rrqq_pkg::STAT_FULL;
              end else begin
                out_status_d = rrqq_pkg::STAT_ADDED;
                ram_we       = 1'b1;
                tail_d       = tail_nxt;
                count_d      = count_q + CNT_W'(1);
                sum_d        = sum_q + jt_ext;
              end
            end
          end
          rrqq_pkg::CMD_SERVE: begin
            if (out_free) begin
              out_valid_d   = 1'b1;
              out_granted_d = '0;
              out_done_d    = 1'b0;
              out_mean_d    = '0;
              state_d       = rrqq_pkg::S_IDLE;
              if (empty) begin
                out_status_d = rrqq_pkg::STAT_EMPTY;
              end else begin
                out_status_d = rrqq_pkg::STAT_SERVED;
                head_d       = head_nxt;
                if (ram_rdata > quantum_q) begin
                  out_granted_d = quantum_q;
                  ram_we        = 1'b1;
                  ram_wdata     = ram_rdata - quantum_q;
                  tail_d        = tail_nxt;
                  sum_d         = sum_q - quantum_ext;
                end else begin
                  out_granted_d = ram_rdata;
                  out_done_d    = 1'b1;
                  count_d       = count_q - CNT_W'(1);
                  sum_d         = sum_q - rdata_ext;
                end
              end
            end
          end
          rrqq_pkg::CMD_AVG: begin
            if (!empty) begin
              div_start = 1'b1;
              state_d   = rrqq_pkg::S_DIV;
            end else if (out_free) begin
              out_valid_d   = 1'b1;
              out_status_d  = rrqq_pkg::STAT_EMPTY;
              out_granted_d = '0;
              out_done_d    = 1'b0;
              out_mean_d    = '0;
              state_d       = rrqq_pkg::S_IDLE;
            end
          end
          default: begin
            state_d = rrqq_pkg::S_IDLE;
          end
        endcase
      end
      rrqq_pkg::S_DIV: begin
        if (div_done) begin
          state_d = rrqq_pkg::S_AVG;
        end
      end
      rrqq_pkg::S_AVG: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_status_d  = rrqq_pkg::STAT_AVERAGE;
          out_granted_d = '0;
          out_done_d    = 1'b0;
          out_mean_d    = div_quot[rrqq_pkg::MEAN_W-1:0];
          state_d       = rrqq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rrqq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrqq_pkg::S_IDLE;
      quantum_q   <= rrqq_pkg::QUANTUM_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      quantum_q   <= quantum_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    jt_q          <= jt_d;
    out_status_q  <= out_status_d;
    out_granted_q <= out_granted_d;
    out_done_q    <= out_done_d;
    out_mean_q    <= out_mean_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {{rrqq_pkg::OUT_PAD_W{1'b0}}, out_mean_q, out_done_q, out_granted_q};

endmodule
